### hw/rtl/modular_inverse_assert.svh
// assertion macros shared by the modular inverse rtl
// no dependencies; included by the modules that carry assertions
`ifndef MODULAR_INVERSE_ASSERT_SVH
`define MODULAR_INVERSE_ASSERT_SVH

// checked only while out of reset
`define MINV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MINV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hw/rtl/minv_pkg.sv
// shared types for the modular inverse block
// controller states and the command / status bundles between controller and datapath
package minv_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_DIVIDE,
        ST_UPDATE,
        ST_FINISH
    } t_minv_state;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture a new request
        logic div_init;  // start a quotient for the current remainder pair
        logic div_step;  // one restoring division bit
        logic commit;    // advance remainders and convergents
        logic finish;    // result taken into the output register
    } t_minv_cmd;

    // datapath to controller
    typedef struct packed {
        logic bad;       // zero value or value not below modulus
        logic r1_zero;   // remainder sequence has ended
        logic div_last;  // last quotient bit this cycle
    } t_minv_sts;

endpackage

### hw/rtl/minv_dp.sv
// datapath: remainder pair, convergent pair and a bit-serial divider
// depends on minv_pkg
module minv_dp import minv_pkg::*; #(
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  t_minv_cmd            i_cmd,
    input  logic [WORD_BITS-1:0] i_value,
    input  logic [WORD_BITS-1:0] i_modulus,
    output t_minv_sts            o_sts,
    output logic [31:0]          o_inverse,
    output logic                 o_no_inverse
);
    localparam int CNT_W = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] r_r0, r_r1, r_t0, r_t1, r_m;
    logic [WORD_BITS-1:0] r_rem, r_dvd, r_acc;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_bad, r_par;

    logic [WORD_BITS:0]   trial;
    logic                 ge;
    logic [WORD_BITS-1:0] n_rem;
    logic [WORD_BITS-1:0] n_acc;
    logic [WORD_BITS-1:0] coef;
    logic                 ok;

    // restoring division, one quotient bit per cycle, msb first
    assign trial = {r_rem, r_dvd[WORD_BITS-1]};
    assign ge    = trial >= {1'b0, r_r1};
    assign n_rem = ge ? WORD_BITS'(trial - {1'b0, r_r1}) : trial[WORD_BITS-1:0];
    // horner form of q * t1 as the quotient bits appear
    assign n_acc = {r_acc[WORD_BITS-2:0], 1'b0} + (ge ? r_t1 : '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_r0  <= i_modulus;
            r_r1  <= i_value;
            r_m   <= i_modulus;
            r_t0  <= '0;
            r_t1  <= WORD_BITS'(1);
            r_par <= 1'b0;
            r_bad <= (i_value == '0) || (i_value >= i_modulus);
        end else if (i_cmd.commit) begin
            r_r0  <= r_r1;
            r_r1  <= r_rem;
            r_t0  <= r_t1;
            r_t1  <= r_acc + r_t0;
            r_par <= ~r_par;
        end
        if (i_cmd.div_init) begin
            r_dvd <= r_r0;
            r_rem <= '0;
            r_acc <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[WORD_BITS-2:0], 1'b0};
            r_rem <= n_rem;
            r_acc <= n_acc;
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    assign o_sts.bad      = r_bad;
    assign o_sts.r1_zero  = (r_r1 == '0);
    assign o_sts.div_last = (r_cnt == CNT_W'(WORD_BITS - 1));

    // odd step count keeps the coefficient positive, even negates it mod m
    assign coef         = r_par ? r_t0 : (r_m - r_t0);
    assign ok           = !r_bad && (r_r0 == WORD_BITS'(1));
    assign o_inverse    = ok ? 32'(coef) : 32'd0;
    assign o_no_inverse = !ok;

endmodule

### hw/rtl/minv_ctrl.sv
// controller state machine sequencing the euclid steps
// depends on minv_pkg and modular_inverse_assert.svh
`include "modular_inverse_assert.svh"
module minv_ctrl import minv_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_out_free,
    input  t_minv_sts i_sts,
    output logic      o_in_ready,
    output t_minv_cmd o_cmd
);
    t_minv_state r_state, n_state;
    logic        div_done;

    assign div_done = (r_state == ST_DIVIDE) && i_sts.div_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // no request is taken while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_TEST;
                end
            end
            ST_TEST: begin
                if (i_sts.bad || i_sts.r1_zero) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_state        = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.commit = 1'b1;
                n_state      = ST_TEST;
            end
            ST_FINISH: begin
                if (i_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `MINV_ASSERT_ALWAYS(a_cmd_onehot, $onehot0(o_cmd), "more than one datapath command")
    `MINV_ASSERT(a_div_to_update, div_done |=> (r_state == ST_UPDATE), "divide overran")
    `MINV_ASSERT(a_load_to_test, o_cmd.load |=> (r_state == ST_TEST), "load not followed by test")

endmodule

### hw/rtl/modular_inverse.sv
// each euclid step runs test, the divide bits and update; after the last step come test, finish
// and the output register (about 46 euclid steps at worst for 32-bit operands)
// flagged inputs go from test straight to finish; the bit-serial divider, one quotient bit per cycle,
// sets the run time; one request in flight: no new one is taken until the last reaches finish,
// and the controller waits in finish while a result is still pending in the output register
// reset (i_rst_n, synchronous, active low) returns the controller to idle, empties the output
`include "modular_inverse_assert.svh"
module modular_inverse import minv_pkg::*; #(
    parameter int WORD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // value [31:0], modulus [63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // inverse [31:0]
    output logic        m_axis_tuser    // no_inverse [0]
);
    t_minv_cmd   cmd;
    t_minv_sts   sts;
    logic [31:0] dp_inverse;
    logic        dp_no_inverse;
    logic        out_free;
    logic        in_fire;
    logic        out_flagged;

    // output register parting the compute side from the result channel
    logic        r_out_valid;
    logic [31:0] r_out_inverse;
    logic        r_out_flag;

    // free when empty or being drained this cycle
    assign out_free = !r_out_valid || m_axis_tready;

    minv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    // operands are cut or zero-extended to the working width
    minv_dp #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_value      (WORD_BITS'(s_axis_tdata[31:0])),
        .i_modulus    (WORD_BITS'(s_axis_tdata[63:32])),
        .o_sts        (sts),
        .o_inverse    (dp_inverse),
        .o_no_inverse (dp_no_inverse)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.finish) begin
            r_out_inverse <= dp_inverse;
            r_out_flag    <= dp_no_inverse;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_inverse;
    assign m_axis_tuser  = r_out_flag;

    // handshake terms for the checks below
    assign in_fire     = s_axis_tvalid && s_axis_tready;
    assign out_flagged = m_axis_tvalid && m_axis_tuser;

    `MINV_ASSERT(a_busy_after_accept, in_fire |=> !s_axis_tready, "request taken while busy")
    `MINV_ASSERT(a_flag_zero_result, out_flagged |-> (m_axis_tdata == '0), "flagged result not zero")
    `MINV_ASSERT(a_no_overwrite, cmd.finish |-> out_free, "result loaded over a pending one")

endmodule
